// ----- design/sqrt_curve_p_controller_defines.svh -----
// Assertion macros for the square-root curve P controller.
`ifndef SQRT_CURVE_P_CONTROLLER_DEFINES_SVH
`define SQRT_CURVE_P_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only out of reset.
`define SCPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every edge, reset included.
`define SCPC_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SCPC_ASSERT(lbl, prop, msg)
`define SCPC_ASSERT_NR(lbl, prop, msg)
`endif

`endif

// ----- design/scpc_pkg.sv -----
`timescale 1ns / 1ps

package scpc_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned FracBits  = 16;

  localparam int unsigned ErrW   = DataWidth + 1;              // target - measured
  localparam int unsigned MagW   = DataWidth + 1;              // |error|
  localparam int unsigned DistW  = DataWidth + 2;              // |error| - x offset
  localparam int unsigned ProdW  = DataWidth + MagW;           // shared multiplier
  localparam int unsigned RadW   = 2 * DataWidth;              // saturated radicand
  localparam int unsigned RootW  = DataWidth;
  localparam int unsigned RemW   = RootW + 3;
  localparam int unsigned SqBits = 2;                          // root bits per stage
  localparam int unsigned SqStages = RootW / SqBits;
  localparam int unsigned LinW   = 2 * DataWidth - 1 - FracBits; // linear magnitude
  localparam int unsigned ValW   = DataWidth + 2;              // root + y offset
  localparam int unsigned DrvW   = LinW + 2;                   // signed drive before clamp
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgGain          = 3'd0,
    CfgTwiceAccel    = 3'd1,
    CfgLinearBand    = 3'd2,
    CfgCurveXOffset  = 3'd3,
    CfgCurveYOffset  = 3'd4,
    CfgOutputLimit   = 3'd5,
    CfgWrapEnable    = 3'd6,
    CfgWrapHalfRange = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [DataWidth-1:0] gain;
    logic [DataWidth-1:0] twice_accel;
    logic [DataWidth-2:0] linear_band;
    logic [DataWidth-1:0] curve_x_offset;
    logic [DataWidth-1:0] curve_y_offset;
    logic [DataWidth-2:0] output_limit;
    logic                 wrap_enable;
    logic [DataWidth-3:0] wrap_half_range;
  } cfg_t;

  // front end -> square root
  typedef struct packed {
    logic [ProdW-1:0] prod;
    logic             lin;
    logic             neg;
  } front_t;

  // carried alongside the root
  typedef struct packed {
    logic            lin;
    logic            neg;
    logic [LinW-1:0] lin_mag;
  } side_t;

  // square root -> back end
  typedef struct packed {
    logic [RootW-1:0] root;
    side_t            side;
  } back_t;

endpackage

// ----- design/sqrt_curve_p_controller.sv -----
// Square-root braking-curve P controller, signed Q16.16 throughout.
// Input stream s_axis: one request carries target and measured; the error is
// target - measured, optionally folded once into +/- wrap_half_range.
// Small errors get error * gain; larger ones get
// sign(error) * (sqrt(twice_accel * ||error| - x_offset|) + y_offset).
// The drive is clamped to +/- output_limit; m_axis_tuser flags the clamp.
// Output stream m_axis: one result per request, in request order.
// Configuration: cfg_we_i writes register cfg_addr_i on the clock edge;
// write only while no request is in flight.
// Pipeline: 6 front-end stages up to the shared 32x33 multiplier,
// 16 square-root stages at two root bits each, 3 stages for offset,
// sign and clamp.
// Throughput: one request per cycle unless stalled. Every stage holds its
// own valid bit, so a stalled receiver only holds the output stage; empty
// stages upstream keep filling and s_axis_tready drops once the pipe is full.
// Reset clears all valid bits and all configuration registers.
`timescale 1ns / 1ps
`include "sqrt_curve_p_controller_defines.svh"

module sqrt_curve_p_controller (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [scpc_pkg::CfgIdxW-1:0]          cfg_addr_i,
  input  logic [scpc_pkg::DataWidth-1:0]        cfg_wdata_i,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [2*scpc_pkg::DataWidth-1:0]      s_axis_tdata,  // target, measured
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [scpc_pkg::DataWidth-1:0]        m_axis_tdata,  // drive
  output logic                                  m_axis_tuser   // limited
);
  import scpc_pkg::*;

  cfg_t   cfg_q;
  logic   fr_valid, fr_ready, sq_valid, sq_ready;
  front_t fr_data;
  back_t  sq_data;
  logic [DataWidth-1:0] lim_pos, lim_neg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CfgGain:          cfg_q.gain            <= cfg_wdata_i;
        CfgTwiceAccel:    cfg_q.twice_accel     <= cfg_wdata_i;
        CfgLinearBand:    cfg_q.linear_band     <= cfg_wdata_i[DataWidth-2:0];
        CfgCurveXOffset:  cfg_q.curve_x_offset  <= cfg_wdata_i;
        CfgCurveYOffset:  cfg_q.curve_y_offset  <= cfg_wdata_i;
        CfgOutputLimit:   cfg_q.output_limit    <= cfg_wdata_i[DataWidth-2:0];
        CfgWrapEnable:    cfg_q.wrap_enable     <= cfg_wdata_i[0];
        CfgWrapHalfRange: cfg_q.wrap_half_range <= cfg_wdata_i[DataWidth-3:0];
        default: ;
      endcase
    end
  end

  scpc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .target_i    (s_axis_tdata[DataWidth-1:0]),
    .measured_i  (s_axis_tdata[2*DataWidth-1:DataWidth]),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_o       (fr_data)
  );

  scpc_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_i        (fr_data),
    .out_valid_o (sq_valid),
    .out_ready_i (sq_ready),
    .out_o       (sq_data)
  );

  scpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (sq_valid),
    .in_ready_o  (sq_ready),
    .in_i        (sq_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .drive_o     (m_axis_tdata),
    .limited_o   (m_axis_tuser)
  );

  assign lim_pos = {1'b0, cfg_q.output_limit};
  assign lim_neg = -lim_pos;

  `SCPC_ASSERT_NR(a_reset_empty, !rst_ni |=> !m_axis_tvalid, "result valid after reset edge")
  `SCPC_ASSERT(a_empty_ready, !m_axis_tvalid |-> s_axis_tready, "empty pipe refuses request")
  `SCPC_ASSERT(a_limited_value, m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata == lim_pos) || (m_axis_tdata == lim_neg), "clamp flag without limit value")
  `SCPC_ASSERT(a_in_range, m_axis_tvalid |-> ($signed(m_axis_tdata) <= $signed(lim_pos)) && ($signed(m_axis_tdata) >= $signed(lim_neg)), "drive outside limit")

endmodule

// ----- design/scpc_front.sv -----
`timescale 1ns / 1ps

module scpc_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  scpc_pkg::cfg_t                  cfg_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [scpc_pkg::DataWidth-1:0]  target_i,
  input  logic [scpc_pkg::DataWidth-1:0]  measured_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output scpc_pkg::front_t                out_o
);
  import scpc_pkg::*;

  localparam int unsigned NumStages = 6;

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] en;

  logic signed [ErrW-1:0]  err0_d, err0_q;
  logic signed [ErrW-1:0]  err1_d, err1_q;
  logic signed [ErrW-1:0]  half_s, twice_s;
  logic [MagW-1:0]         mag2_d, mag2_q, mag3_q;
  logic                    neg2_q, neg3_q, neg4_q, neg5_q;
  logic                    lin3_d, lin3_q, lin4_q, lin5_q;
  logic signed [DistW-1:0] dist3_d, dist3_q, dabs;
  logic [DataWidth-1:0]    a4_d, a4_q;
  logic [MagW-1:0]         b4_d, b4_q;
  logic [ProdW-1:0]        prod5_d, prod5_q;

  // stage k loads when it is empty or its content moves on
  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_comb begin
    err0_d = $signed({target_i[DataWidth-1], target_i})
           - $signed({measured_i[DataWidth-1], measured_i});

    // single wrap fold
    half_s  = $signed(ErrW'(cfg_i.wrap_half_range));
    twice_s = $signed(ErrW'({cfg_i.wrap_half_range, 1'b0}));
    err1_d  = err0_q;
    if (cfg_i.wrap_enable && (err0_q > half_s)) begin
      err1_d = err0_q - twice_s;
    end else if (cfg_i.wrap_enable && (err0_q < -half_s)) begin
      err1_d = err0_q + twice_s;
    end

    mag2_d = err1_q[ErrW-1] ? MagW'(-err1_q) : MagW'(err1_q);

    lin3_d  = mag2_q <= MagW'(cfg_i.linear_band);
    dist3_d = $signed({1'b0, mag2_q})
            - $signed({{(DistW-DataWidth){cfg_i.curve_x_offset[DataWidth-1]}},
                       cfg_i.curve_x_offset});

    dabs = dist3_q[DistW-1] ? -dist3_q : dist3_q;
    a4_d = lin3_q ? cfg_i.gain : cfg_i.twice_accel;
    b4_d = lin3_q ? mag3_q : dabs[MagW-1:0];

    prod5_d = ProdW'(a4_q) * ProdW'(b4_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      err0_q <= err0_d;
    end
    if (en[1]) begin
      err1_q <= err1_d;
    end
    if (en[2]) begin
      mag2_q <= mag2_d;
      neg2_q <= err1_q[ErrW-1];
    end
    if (en[3]) begin
      mag3_q  <= mag2_q;
      neg3_q  <= neg2_q;
      lin3_q  <= lin3_d;
      dist3_q <= dist3_d;
    end
    if (en[4]) begin
      a4_q   <= a4_d;
      b4_q   <= b4_d;
      lin4_q <= lin3_q;
      neg4_q <= neg3_q;
    end
    if (en[5]) begin
      prod5_q <= prod5_d;
      lin5_q  <= lin4_q;
      neg5_q  <= neg4_q;
    end
  end

  assign out_valid_o = valid_q[NumStages-1];
  assign out_o       = '{prod: prod5_q, lin: lin5_q, neg: neg5_q};

endmodule

// ----- design/scpc_sqrt.sv -----
`timescale 1ns / 1ps

module scpc_sqrt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  scpc_pkg::front_t  in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output scpc_pkg::back_t   out_o
);
  import scpc_pkg::*;

  logic [SqStages-1:0] valid_q;
  logic [SqStages-1:0] en;

  logic [RemW-1:0]  rem_q  [SqStages];
  logic [RootW-1:0] root_q [SqStages];
  logic [RadW-1:0]  x_q    [SqStages];
  side_t            side_q [SqStages];

  logic [RemW-1:0]  rem_d  [SqStages];
  logic [RootW-1:0] root_d [SqStages];
  logic [RadW-1:0]  x_d    [SqStages];
  side_t            side_d [SqStages];

  logic [RadW-1:0]  rad;
  side_t            side_in;

  always_comb begin
    en[SqStages-1] = !valid_q[SqStages-1] || out_ready_i;
    for (int k = SqStages - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  // radicand saturates at all ones
  assign rad = in_i.prod[ProdW-1] ? '1 : in_i.prod[RadW-1:0];
  assign side_in = '{lin: in_i.lin, neg: in_i.neg,
                     lin_mag: in_i.prod[2*DataWidth-2:FracBits]};

  // restoring digit recurrence, SqBits root bits per stage
  always_comb begin
    logic [RemW-1:0]  r;
    logic [RootW-1:0] q;
    logic [RadW-1:0]  x;
    logic [RemW-1:0]  trial;
    for (int s = 0; s < SqStages; s++) begin
      if (s == 0) begin
        r = '0;
        q = '0;
        x = rad;
        side_d[s] = side_in;
      end else begin
        r = rem_q[s-1];
        q = root_q[s-1];
        x = x_q[s-1];
        side_d[s] = side_q[s-1];
      end
      for (int j = 0; j < SqBits; j++) begin
        r     = {r[RemW-3:0], x[RadW-1 -: 2]};
        x     = {x[RadW-3:0], 2'b00};
        trial = RemW'({q, 2'b01});
        if (r >= trial) begin
          r = r - trial;
          q = {q[RootW-2:0], 1'b1};
        end else begin
          q = {q[RootW-2:0], 1'b0};
        end
      end
      rem_d[s]  = r;
      root_d[s] = q;
      x_d[s]    = x;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < SqStages; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < SqStages; k++) begin
      if (en[k]) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        x_q[k]    <= x_d[k];
        side_q[k] <= side_d[k];
      end
    end
  end

  assign out_valid_o = valid_q[SqStages-1];
  assign out_o       = '{root: root_q[SqStages-1], side: side_q[SqStages-1]};

endmodule

// ----- design/scpc_back.sv -----
`timescale 1ns / 1ps

module scpc_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  scpc_pkg::cfg_t                  cfg_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  scpc_pkg::back_t                 in_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [scpc_pkg::DataWidth-1:0]  drive_o,
  output logic                            limited_o
);
  import scpc_pkg::*;

  localparam int unsigned NumStages = 3;

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] en;

  logic signed [ValW-1:0] val0_d, val0_q;
  side_t                  side0_q;
  logic signed [DrvW-1:0] lin_s, crv_s, drv1_d, drv1_q;
  logic signed [DrvW-1:0] lim_s, clamp;
  logic [DataWidth-1:0]   drive_d, drive_q;
  logic                   limited_d, limited_q;

  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_comb begin
    val0_d = $signed({2'b00, in_i.root})
           + $signed({{(ValW-DataWidth){cfg_i.curve_y_offset[DataWidth-1]}},
                      cfg_i.curve_y_offset});

    // sign of the error applies in both laws, even to a negative curve value
    lin_s = $signed(DrvW'(side0_q.lin_mag));
    crv_s = {{(DrvW-ValW){val0_q[ValW-1]}}, val0_q};
    if (side0_q.lin) begin
      drv1_d = side0_q.neg ? -lin_s : lin_s;
    end else begin
      drv1_d = side0_q.neg ? -crv_s : crv_s;
    end

    lim_s     = $signed(DrvW'(cfg_i.output_limit));
    clamp     = drv1_q;
    limited_d = 1'b0;
    if (drv1_q > lim_s) begin
      clamp     = lim_s;
      limited_d = 1'b1;
    end else if (drv1_q < -lim_s) begin
      clamp     = -lim_s;
      limited_d = 1'b1;
    end
    drive_d = clamp[DataWidth-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      val0_q  <= val0_d;
      side0_q <= in_i.side;
    end
    if (en[1]) begin
      drv1_q <= drv1_d;
    end
    if (en[2]) begin
      drive_q   <= drive_d;
      limited_q <= limited_d;
    end
  end

  assign out_valid_o = valid_q[NumStages-1];
  assign drive_o     = drive_q;
  assign limited_o   = limited_q;

endmodule

// ----- bench/sqrt_curve_p_controller_tb.sv -----
`timescale 1ns / 1ps

module sqrt_curve_p_controller_tb;
  import scpc_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned BatchLen   = 333;
  localparam int unsigned DrainWait  = 40;

  typedef struct packed {
    logic [DataWidth-1:0] drive;
    logic                 limited;
  } ctl_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]     cfg_addr_i = '0;
  logic [DataWidth-1:0]   cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [2*DataWidth-1:0] s_axis_tdata = '0;  // target, measured
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [DataWidth-1:0]   m_axis_tdata;       // drive
  logic                   m_axis_tuser;       // limited

  sqrt_curve_p_controller u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  // shadow copy of the controller registers
  longint gain_r  = 0;
  longint accel_r = 0;
  longint band_r  = 0;
  longint xoff_r  = 0;
  longint yoff_r  = 0;
  longint limit_r = 0;
  longint wrap_r  = 0;
  longint half_r  = 0;

  logic [2*DataWidth-1:0] sample_q[$];
  ctl_result_t            drive_exp_q[$];

  int unsigned send_idle_pct = 20;
  int unsigned recv_idle_pct = 71;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic ctl_result_t predict_drive(logic [DataWidth-1:0] tgt,
                                                logic [DataWidth-1:0] meas);
    longint      err;
    longint      mag;
    longint      span;
    longint      drv;
    logic [127:0] prod;
    logic [63:0] p;
    logic [63:0] rad;
    ctl_result_t res;
    err = $signed({{32{tgt[31]}}, tgt}) - $signed({{32{meas[31]}}, meas});
    if (wrap_r != 0) begin
      if (err > half_r) err = err - 2 * half_r;
      else if (err < -half_r) err = err + 2 * half_r;
    end
    mag = (err < 0) ? -err : err;
    if (mag <= band_r) begin
      prod = {64'b0, 64'(mag)} * {64'b0, 64'(gain_r)};
      if (prod[127:80] != 0) begin
        p = 64'h4000_0000_0000_0000;
      end else begin
        p = prod[79:16];
        if (p > 64'h4000_0000_0000_0000) p = 64'h4000_0000_0000_0000;
      end
      drv = (err < 0) ? -longint'(p) : longint'(p);
    end else begin
      span = mag - xoff_r;
      if (span < 0) span = -span;
      prod = {64'b0, 64'(accel_r)} * {64'b0, 64'(span)};
      rad = (prod[127:64] != 0) ? '1 : prod[63:0];
      drv = longint'(floor_sqrt(rad)) + yoff_r;
      if (err <= 0) drv = -drv;
    end
    res.limited = 1'b0;
    if (drv > limit_r) begin
      drv = limit_r;
      res.limited = 1'b1;
    end else if (drv < -limit_r) begin
      drv = -limit_r;
      res.limited = 1'b1;
    end
    res.drive = drv[DataWidth-1:0];
    return res;
  endfunction

  function automatic logic [31:0] rnd_scaled();
    return $urandom >> $urandom_range(31);
  endfunction

  function automatic logic [31:0] rnd_signed_scaled();
    logic [31:0] v;
    v = rnd_scaled();
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  // some errors near the band edge, the wrap fold or zero, the rest random
  function automatic logic [63:0] random_sample();
    logic [31:0] meas;
    logic [31:0] delta;
    int unsigned pick;
    meas = $urandom;
    pick = $urandom_range(99);
    if (pick < 45) begin
      delta = rnd_signed_scaled();
    end else if (pick < 60) begin
      delta = 32'(half_r) + 32'($urandom_range(6)) - 32'd3;
      if ($urandom_range(1)) delta = -delta;
    end else if (pick < 70) begin
      delta = 32'(band_r) + 32'($urandom_range(6)) - 32'd3;
      if ($urandom_range(1)) delta = -delta;
    end else if (pick < 75) begin
      delta = '0;
    end else begin
      return {meas, 32'($urandom)};
    end
    return {meas, meas + delta};
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgGain:          gain_r  = longint'({32'b0, val});
      CfgTwiceAccel:    accel_r = longint'({32'b0, val});
      CfgLinearBand:    band_r  = longint'({33'b0, val[30:0]});
      CfgCurveXOffset:  xoff_r  = $signed({{32{val[31]}}, val});
      CfgCurveYOffset:  yoff_r  = $signed({{32{val[31]}}, val});
      CfgOutputLimit:   limit_r = longint'({33'b0, val[30:0]});
      CfgWrapEnable:    wrap_r  = longint'(val[0]);
      CfgWrapHalfRange: half_r  = longint'({34'b0, val[29:0]});
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [31:0] gain, input logic [31:0] accel,
                              input logic [31:0] band, input logic [31:0] xoff,
                              input logic [31:0] yoff, input logic [31:0] limit,
                              input logic [31:0] wrap, input logic [31:0] half);
    write_reg(CfgGain, gain);
    write_reg(CfgTwiceAccel, accel);
    write_reg(CfgLinearBand, band);
    write_reg(CfgCurveXOffset, xoff);
    write_reg(CfgCurveYOffset, yoff);
    write_reg(CfgOutputLimit, limit);
    write_reg(CfgWrapEnable, wrap);
    write_reg(CfgWrapHalfRange, half);
  endtask

  task automatic random_config();
    logic [31:0] limit;
    limit = ($urandom_range(3) == 0) ? 32'hffff_ffff : rnd_scaled();
    apply_config(rnd_scaled(), rnd_scaled(), rnd_scaled(), rnd_signed_scaled(),
                 rnd_signed_scaled(), limit, $urandom, rnd_scaled());
  endtask

  // sampled on the falling edge so the driver's updates have settled
  task automatic wait_drained();
    @(negedge clk_i);
    while (sample_q.size() != 0 || s_axis_tvalid || drive_exp_q.size() != 0)
      @(negedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic push_sample(input logic [31:0] tgt, input logic [31:0] meas);
    sample_q.push_back({meas, tgt});
  endtask

  // request driver
  always @(posedge clk_i) begin : drv_p
    logic [2*DataWidth-1:0] nxt;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        drive_exp_q.push_back(predict_drive(s_axis_tdata[31:0], s_axis_tdata[63:32]));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = sample_q.pop_front();
          s_axis_tdata  <= nxt;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result monitor
  always @(posedge clk_i) begin : mon_p
    ctl_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (drive_exp_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: drive=%h limited=%b", m_axis_tdata, m_axis_tuser);
      end else begin
        exp_r = drive_exp_q.pop_front();
        if (m_axis_tdata !== exp_r.drive || m_axis_tuser !== exp_r.limited) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("drive mismatch: exp drive=%h limited=%b, got drive=%h limited=%b",
                     exp_r.drive, exp_r.limited, m_axis_tdata, m_axis_tuser);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 20;
    recv_idle_pct = 71;

    // unity gain, small band, plain curve
    apply_config(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0, 32'h0,
                 32'h7fff_ffff, 32'h0, 32'h0);
    push_sample(32'h0, 32'h0);
    push_sample(32'h7fff_ffff, 32'h8000_0000);  // largest positive error
    push_sample(32'h8000_0000, 32'h7fff_ffff);  // largest negative error
    push_sample(32'h0001_0000, 32'h0);          // exactly on the band
    push_sample(32'h0, 32'h0001_0000);
    push_sample(32'h0001_0001, 32'h0);          // just past the band
    push_sample(32'h0000_5000, 32'h0000_1000);
    push_sample(32'h8000_0000, 32'h8000_0000);
    push_sample(32'h7fff_ffff, 32'h7fff_ffff);
    wait_drained();

    // extremes: full gain, zero clamp, widest fold, saturating radicand
    apply_config(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000,
                 32'h7fff_ffff, 32'h0, 32'h1, 32'hffff_ffff);
    push_sample(32'h7fff_ffff, 32'h8000_0000);
    push_sample(32'h4000_0000, 32'h0);
    push_sample(32'h0, 32'h0);
    push_sample(32'h3fff_ffff, 32'h0);
    push_sample(32'h0, 32'h3fff_ffff);
    wait_drained();

    // negative y offset flips the curve, fold with zero half range, no band
    apply_config(32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'h7fff_ffff,
                 32'h8000_0000, 32'h7fff_ffff, 32'h1, 32'h0);
    push_sample(32'h7fff_ffff, 32'h8000_0000);
    push_sample(32'h1, 32'h0);
    push_sample(32'h0, 32'h1);
    push_sample(32'h8000_0000, 32'h7fff_ffff);
    wait_drained();

    // moderate settings with clamping on both sides
    apply_config(32'h0002_8000, 32'h0008_0000, 32'h0000_8000, 32'h0000_4000,
                 32'h0001_0000, 32'h0003_0000, 32'h0, 32'h0003_243f);
    push_sample(32'h0000_4000, 32'h0);
    push_sample(32'h0, 32'h0000_4000);
    push_sample(32'h0100_0000, 32'h0);
    push_sample(32'h0, 32'h0100_0000);
    push_sample(32'h0000_9000, 32'h0000_1000);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 71;
        recv_idle_pct = 20;
      end else if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_config();
      for (int n = 0; n < BatchLen; n++) sample_q.push_back(random_sample());
      wait_drained();
    end

    if (mismatch_cnt == 0 && drive_exp_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
